// File: hdl/phms_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the packed Hessenberg matrix store.
// No dependencies; every other file takes names from here, by scope or by import.

package phms_pkg;

    localparam int MAX_N       = 32;
    localparam int IDX_W       = $clog2(MAX_N);
    localparam int N_W         = $clog2(MAX_N + 1);
    localparam int STORE_DEPTH = (MAX_N * (MAX_N + 3)) / 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CMP_W       = ((N_W > 6) ? N_W : 6) + 1;

    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int SUM_W       = PROD_W - 16 + 2;
    localparam int OP_W        = 3;
    localparam int MSIZE_W     = 6;
    localparam int OUT_IDX_W   = 5;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAD_W     = M_TDATA_W - DATA_W - OUT_IDX_W;

    localparam logic [MSIZE_W-1:0] MSIZE_RESET = MSIZE_W'(32);
    localparam logic [DATA_W-1:0]  Q_ONE       = 32'h0001_0000;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_IDENT = 3'd2,
        OP_LOAD  = 3'd3,
        OP_MUL   = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_ZERO  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_IDENT,
        S_MUL
    } state_t;

    typedef enum logic [1:0] {
        RES_CONST,
        RES_READ,
        RES_MAC
    } res_sel_t;

    // One pipeline slot: a multiply element or a single-result operation
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             last;
        logic             first;
        res_sel_t         sel;
        status_t          status;
        logic [IDX_W-1:0] row;
    } token_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } store_req_t;

    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  b_raddr;
        logic [IDX_W-1:0]  x_raddr;
        logic              ld_we;
        logic [IDX_W-1:0]  ld_addr;
        logic [DATA_W-1:0] b_wdata;
        logic [DATA_W-1:0] x_wdata;
    } vec_req_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } acc_wb_t;

    // Offset of row r in the packed store: r*(r+3)/2
    function automatic logic [ADDR_W-1:0] row_base(input logic [IDX_W-1:0] r);
        logic [ADDR_W:0] rr;
        logic [ADDR_W:0] prod;
        rr   = (ADDR_W + 1)'(r);
        prod = rr * (rr + (ADDR_W + 1)'(3));
        return ADDR_W'(prod >> 1);
    endfunction

endpackage

// File: hdl/phms_store_mem.sv
`timescale 1ns / 1ps
// Single-port synchronous RAM holding the packed matrix rows.
// Depends on phms_pkg for depth, widths and the request struct.

module phms_store_mem (
    input  logic                              aclk,
    input  phms_pkg::store_req_t              req,
    output logic [phms_pkg::DATA_W-1:0]       rdata
);

    logic [phms_pkg::DATA_W-1:0] mem [phms_pkg::STORE_DEPTH];
    logic [phms_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            if (req.we) begin
                mem[req.addr] <= req.wdata;
            end else begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/phms_vec_mem.sv
`timescale 1ns / 1ps
// Operand and accumulator vector RAMs, one read port each, registered data.
// Depends on phms_pkg for widths and the request and write-back structs.

module phms_vec_mem (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  phms_pkg::vec_req_t           req,
    input  phms_pkg::acc_wb_t            wb,
    output logic [phms_pkg::DATA_W-1:0]  b_rdata,
    output logic [phms_pkg::DATA_W-1:0]  x_rdata
);

    logic [phms_pkg::DATA_W-1:0] b_mem [phms_pkg::MAX_N];
    logic [phms_pkg::DATA_W-1:0] x_mem [phms_pkg::MAX_N];
    logic [phms_pkg::DATA_W-1:0] b_rdata_reg;
    logic [phms_pkg::DATA_W-1:0] x_rdata_reg;
    logic                        x_we;
    logic [phms_pkg::IDX_W-1:0]  x_waddr;
    logic [phms_pkg::DATA_W-1:0] x_wdata;

    // Loads and row write-backs share the accumulator write port
    always_comb begin
        x_we    = req.ld_we | wb.we;
        x_waddr = req.ld_we ? req.ld_addr : wb.addr;
        x_wdata = req.ld_we ? req.x_wdata : wb.data;
    end

    always_ff @(posedge aclk) begin
        if (req.ld_we) begin
            b_mem[req.ld_addr] <= req.b_wdata;
        end
        if (x_we) begin
            x_mem[x_waddr] <= x_wdata;
        end
        if (req.rd_en) begin
            b_rdata_reg <= b_mem[req.b_raddr];
            x_rdata_reg <= x_mem[req.x_raddr];
        end
    end

    assign b_rdata = b_rdata_reg;
    assign x_rdata = x_rdata_reg;

    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.ld_we && wb.we))
        else $error("load and accumulator write-back in the same cycle");

endmodule

// File: hdl/phms_mac.sv
`timescale 1ns / 1ps
// Multiply, round and saturating accumulate stages, plus result selection.
// Depends on phms_pkg for the token type and widths.

module phms_mac (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  phms_pkg::token_t             tok1,
    input  logic [phms_pkg::DATA_W-1:0]  store_q,
    input  logic [phms_pkg::DATA_W-1:0]  b_q,
    input  logic [phms_pkg::DATA_W-1:0]  x_q,
    output phms_pkg::token_t             tok2,
    output logic [phms_pkg::DATA_W-1:0]  res_value,
    output phms_pkg::acc_wb_t            wb
);

    phms_pkg::token_t                   tok2_reg;
    logic signed [phms_pkg::PROD_W-1:0] prod_reg;
    logic [phms_pkg::DATA_W-1:0]        x2_reg;
    logic [phms_pkg::DATA_W-1:0]        acc_reg;
    logic [phms_pkg::DATA_W-1:0]        base;
    logic [phms_pkg::SUM_W-1:0]         sum;
    logic [phms_pkg::DATA_W-1:0]        sat_val;
    logic                               mac_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok2_reg <= '0;
        end else if (adv) begin
            tok2_reg <= tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= $signed(store_q) * $signed(b_q);
            x2_reg   <= (tok1.sel == phms_pkg::RES_READ) ? store_q : x_q;
        end
        if (mac_step) begin
            acc_reg <= sat_val;
        end
    end

    // Round to nearest by folding bit 15 in as a carry into the shifted product
    always_comb begin
        base = tok2_reg.first ? x2_reg : acc_reg;
        sum  = phms_pkg::SUM_W'($signed(base))
             + phms_pkg::SUM_W'($signed(prod_reg[phms_pkg::PROD_W-1:16]))
             + phms_pkg::SUM_W'(prod_reg[15]);
        if (!sum[phms_pkg::SUM_W-1] && (|sum[phms_pkg::SUM_W-2:phms_pkg::DATA_W-1])) begin
            sat_val = {1'b0, {(phms_pkg::DATA_W-1){1'b1}}};
        end else if (sum[phms_pkg::SUM_W-1] && !(&sum[phms_pkg::SUM_W-2:phms_pkg::DATA_W-1])) begin
            sat_val = {1'b1, {(phms_pkg::DATA_W-1){1'b0}}};
        end else begin
            sat_val = sum[phms_pkg::DATA_W-1:0];
        end
    end

    always_comb begin
        mac_step = adv && tok2_reg.valid && (tok2_reg.sel == phms_pkg::RES_MAC);
        case (tok2_reg.sel)
            phms_pkg::RES_MAC:  res_value = sat_val;
            phms_pkg::RES_READ: res_value = x2_reg;
            default:            res_value = '0;
        endcase
        wb.we   = mac_step && tok2_reg.emit;
        wb.addr = tok2_reg.row;
        wb.data = sat_val;
    end

    assign tok2 = tok2_reg;

endmodule

// File: hdl/phms_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: decodes requests, walks the store for identity and multiply,
// issues memory accesses and pipeline tokens. Depends on phms_pkg.

module phms_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic [phms_pkg::N_W-1:0]      n,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [phms_pkg::OP_W-1:0]     in_op,
    input  logic [5:0]                    in_row,
    input  logic [5:0]                    in_col,
    input  logic [phms_pkg::DATA_W-1:0]   in_elem,
    input  logic [phms_pkg::DATA_W-1:0]   in_start,
    input  logic                          mac_tail_busy,
    output phms_pkg::store_req_t          store_req,
    output phms_pkg::vec_req_t            vec_req,
    output phms_pkg::token_t              tok1
);

    localparam int CW = phms_pkg::CMP_W;

    phms_pkg::state_t                state_reg, state_next;
    logic [phms_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic [phms_pkg::IDX_W-1:0]      row_reg, row_next;
    logic [phms_pkg::N_W-1:0]        col_reg, col_next;
    phms_pkg::token_t                tok1_reg;
    phms_pkg::token_t                tok0;
    phms_pkg::op_t                   op;

    logic          accept;
    logic          mac_busy;
    logic          range_bad;
    logic          load_bad;
    logic          above_band;
    logic          row_last;
    logic          ident_row_end;
    logic          diag;
    logic          elem_last;
    logic [CW-1:0] n_c;
    logic [CW-1:0] row_c;
    logic [CW-1:0] col_c;
    logic [CW-1:0] top_c;

    always_comb begin
        op         = phms_pkg::op_t'(in_op);
        mac_busy   = (tok1_reg.valid && (tok1_reg.sel == phms_pkg::RES_MAC)) || mac_tail_busy;
        s_ready    = (state_reg == phms_pkg::S_IDLE) && adv && !mac_busy;
        accept     = s_valid && s_ready;
        n_c        = CW'(n);
        range_bad  = (CW'(in_row) >= n_c) || (CW'(in_col) >= n_c);
        load_bad   = CW'(in_col) >= n_c;
        above_band = CW'(in_col) > (CW'(in_row) + CW'(1));
        row_c      = CW'(row_reg);
        col_c      = CW'(col_reg);
        row_last   = row_c == (n_c - CW'(1));
        top_c      = ((row_c + CW'(1)) < n_c) ? (row_c + CW'(1)) : (n_c - CW'(1));
        elem_last  = col_c == top_c;
        ident_row_end = col_c == (row_c + CW'(1));
        diag       = col_c == row_c;
    end

    // Next state and walk counters
    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        case (state_reg)
            phms_pkg::S_IDLE: begin
                if (accept) begin
                    addr_next = '0;
                    row_next  = '0;
                    col_next  = '0;
                    if (op == phms_pkg::OP_IDENT) begin
                        state_next = phms_pkg::S_IDENT;
                    end else if (op == phms_pkg::OP_MUL) begin
                        state_next = phms_pkg::S_MUL;
                    end
                end
            end
            phms_pkg::S_IDENT, phms_pkg::S_MUL: begin
                if (adv) begin
                    addr_next = addr_reg + phms_pkg::ADDR_W'(1);
                    if ((state_reg == phms_pkg::S_IDENT) ? ident_row_end : elem_last) begin
                        col_next = '0;
                        row_next = row_reg + phms_pkg::IDX_W'(1);
                        if (row_last) begin
                            state_next = phms_pkg::S_IDLE;
                        end
                    end else begin
                        col_next = col_reg + phms_pkg::N_W'(1);
                    end
                end
            end
            default: state_next = phms_pkg::S_IDLE;
        endcase
    end

    // Memory requests and issued token
    always_comb begin
        store_req   = '0;
        vec_req     = '0;
        tok0        = '0;
        tok0.sel    = phms_pkg::RES_CONST;
        tok0.status = phms_pkg::ST_OK;
        case (state_reg)
            phms_pkg::S_IDLE: begin
                if (accept) begin
                    tok0.valid = 1'b1;
                    tok0.emit  = 1'b1;
                    tok0.last  = 1'b1;
                    case (op)
                        phms_pkg::OP_WRITE: begin
                            if (range_bad) begin
                                tok0.status = phms_pkg::ST_RANGE;
                            end else if (above_band) begin
                                tok0.status = phms_pkg::ST_ZERO;
                            end else begin
                                store_req.en    = 1'b1;
                                store_req.we    = 1'b1;
                                store_req.addr  = phms_pkg::row_base(phms_pkg::IDX_W'(in_row))
                                                + phms_pkg::ADDR_W'(phms_pkg::IDX_W'(in_col));
                                store_req.wdata = in_elem;
                            end
                        end
                        phms_pkg::OP_READ: begin
                            if (range_bad) begin
                                tok0.status = phms_pkg::ST_RANGE;
                            end else if (!above_band) begin
                                store_req.en   = 1'b1;
                                store_req.addr = phms_pkg::row_base(phms_pkg::IDX_W'(in_row))
                                               + phms_pkg::ADDR_W'(phms_pkg::IDX_W'(in_col));
                                tok0.sel       = phms_pkg::RES_READ;
                            end
                        end
                        phms_pkg::OP_LOAD: begin
                            if (load_bad) begin
                                tok0.status = phms_pkg::ST_RANGE;
                            end else begin
                                vec_req.ld_we   = 1'b1;
                                vec_req.ld_addr = phms_pkg::IDX_W'(in_col);
                                vec_req.b_wdata = in_elem;
                                vec_req.x_wdata = in_start;
                            end
                        end
                        phms_pkg::OP_IDENT, phms_pkg::OP_MUL: begin
                            tok0.valid = 1'b0;
                        end
                        default: tok0.status = phms_pkg::ST_RANGE;
                    endcase
                end
            end
            phms_pkg::S_IDENT: begin
                if (adv) begin
                    store_req.en    = 1'b1;
                    store_req.we    = 1'b1;
                    store_req.addr  = addr_reg;
                    store_req.wdata = diag ? phms_pkg::Q_ONE : '0;
                    if (ident_row_end && row_last) begin
                        tok0.valid = 1'b1;
                        tok0.emit  = 1'b1;
                        tok0.last  = 1'b1;
                    end
                end
            end
            phms_pkg::S_MUL: begin
                if (adv) begin
                    store_req.en    = 1'b1;
                    store_req.addr  = addr_reg;
                    vec_req.rd_en   = 1'b1;
                    vec_req.b_raddr = col_reg[phms_pkg::IDX_W-1:0];
                    vec_req.x_raddr = row_reg;
                    tok0.valid      = 1'b1;
                    tok0.sel        = phms_pkg::RES_MAC;
                    tok0.first      = col_reg == '0;
                    tok0.emit       = elem_last;
                    tok0.last       = elem_last && row_last;
                    tok0.row        = row_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= phms_pkg::S_IDLE;
            addr_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            tok1_reg  <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (adv) begin
                tok1_reg <= tok0;
            end
        end
    end

    assign tok1 = tok1_reg;

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != phms_pkg::S_IDLE) |-> !s_ready)
        else $error("request taken while a walk is running");

    a_mul_row_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == phms_pkg::S_MUL) && (col_reg == '0))
            |-> (addr_reg == phms_pkg::row_base(row_reg)))
        else $error("multiply walk lost its row alignment");

    a_ident_row_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == phms_pkg::S_IDENT) && (col_reg == '0))
            |-> (addr_reg == phms_pkg::row_base(row_reg)))
        else $error("identity walk lost its row alignment");

endmodule

// File: hdl/packed_hessenberg_matrix_store_unit.sv
`timescale 1ns / 1ps
// Top level of the packed Hessenberg matrix store: size register, output
// register and stall logic around phms_ctrl, phms_store_mem, phms_vec_mem, phms_mac.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid / s_tready  s_tdata, s_tuser (operation)
//  m_       out  m_tvalid / m_tready  m_tdata, m_tuser (status), m_tlast
//  cfg_     in   cfg_valid/cfg_ready  cfg_data (matrix size)
//
// Element write, read, load and error requests are taken one a cycle unless the pipe
// stalls; a result passes the token, accumulate and output registers to m_tvalid.
// Identity writes n(n+3)/2 store words, one a cycle; multiply issues n(n+3)/2-1
// store reads, one a cycle, then holds s_tready low while its last row clears the
// accumulate stage; the single store port sets both, and pipe stalls pause both.
// A full output register with m_tready low stalls the pipeline once a
// result-bearing request reaches the accumulate stage.
// Reset clears control state only; the memories stay undefined until written.

module packed_hessenberg_matrix_store_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // [5:0] row, [11:6] column, [43:12] element_value, [75:44] start_value
    input  logic [phms_pkg::S_TDATA_W-1:0]    s_tdata,
    // [2:0] operation
    input  logic [phms_pkg::OP_W-1:0]         s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] read_value, [36:32] out_index
    output logic [phms_pkg::M_TDATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [phms_pkg::STATUS_W-1:0]     m_tuser,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [phms_pkg::MSIZE_W-1:0]      cfg_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready
);

    localparam int CW = phms_pkg::CMP_W;

    logic [phms_pkg::MSIZE_W-1:0]   msize_reg;
    logic [phms_pkg::N_W-1:0]       n;
    logic                           adv;
    logic                           out_free;
    logic                           emit_now;

    logic                           m_tvalid_reg;
    logic [phms_pkg::DATA_W-1:0]    out_value_reg;
    logic [phms_pkg::OUT_IDX_W-1:0] out_index_reg;
    logic [phms_pkg::STATUS_W-1:0]  out_status_reg;
    logic                           out_last_reg;

    phms_pkg::store_req_t           store_req;
    phms_pkg::vec_req_t             vec_req;
    phms_pkg::acc_wb_t              acc_wb;
    phms_pkg::token_t               tok1;
    phms_pkg::token_t               tok2;
    logic [phms_pkg::DATA_W-1:0]    store_q;
    logic [phms_pkg::DATA_W-1:0]    b_q;
    logic [phms_pkg::DATA_W-1:0]    x_q;
    logic [phms_pkg::DATA_W-1:0]    res_value;
    logic                           mac_tail_busy;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msize_reg <= phms_pkg::MSIZE_RESET;
        end else if (cfg_valid) begin
            msize_reg <= cfg_data;
        end
    end

    // Clamp the programmed size into the built range
    always_comb begin
        if (CW'(msize_reg) < CW'(2)) begin
            n = phms_pkg::N_W'(2);
        end else if (CW'(msize_reg) > CW'(phms_pkg::MAX_N)) begin
            n = phms_pkg::N_W'(phms_pkg::MAX_N);
        end else begin
            n = phms_pkg::N_W'(msize_reg);
        end
    end

    always_comb begin
        out_free      = !m_tvalid_reg || m_tready;
        emit_now      = tok2.valid && tok2.emit;
        adv           = !emit_now || out_free;
        mac_tail_busy = tok2.valid && (tok2.sel == phms_pkg::RES_MAC);
    end

    phms_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .n             (n),
        .s_valid       (s_tvalid),
        .s_ready       (s_tready),
        .in_op         (s_tuser),
        .in_row        (s_tdata[5:0]),
        .in_col        (s_tdata[11:6]),
        .in_elem       (s_tdata[43:12]),
        .in_start      (s_tdata[75:44]),
        .mac_tail_busy (mac_tail_busy),
        .store_req     (store_req),
        .vec_req       (vec_req),
        .tok1          (tok1)
    );

    phms_store_mem u_store (
        .aclk  (aclk),
        .req   (store_req),
        .rdata (store_q)
    );

    phms_vec_mem u_vec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (vec_req),
        .wb      (acc_wb),
        .b_rdata (b_q),
        .x_rdata (x_q)
    );

    phms_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .tok1      (tok1),
        .store_q   (store_q),
        .b_q       (b_q),
        .x_q       (x_q),
        .tok2      (tok2),
        .res_value (res_value),
        .wb        (acc_wb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= emit_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_now && out_free) begin
            out_value_reg  <= res_value;
            out_index_reg  <= phms_pkg::OUT_IDX_W'(tok2.row);
            out_status_reg <= tok2.status;
            out_last_reg   <= tok2.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{phms_pkg::M_PAD_W{1'b0}}, out_index_reg, out_value_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_now && tok2.last && (tok2.sel == phms_pkg::RES_MAC))
            |-> (CW'(tok2.row) == (CW'(n) - CW'(1))))
        else $error("multiply run closed on a row other than the last");

endmodule

// File: sim/tb_packed_hessenberg_matrix_store_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for packed_hessenberg_matrix_store_unit: a directed table, then random
// phases at several matrix sizes, all checked against a shadow model. Depends on phms_pkg.

module tb_packed_hessenberg_matrix_store_unit;
    import phms_pkg::*;

    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam logic [31:0] Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN       = 32'h8000_0000;
    // Operation codes the block does not define
    localparam logic [OP_W-1:0] OP_UNDEF_A = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_B = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_C = 3'd7;

    typedef struct {
        logic [31:0] value;
        logic [4:0]  index;
        logic [1:0]  status;
        logic        last;
    } row_result_t;

    typedef struct {
        bit              size_write;
        logic [OP_W-1:0] op;
        logic [5:0]      row;
        logic [5:0]      col;
        logic [31:0]     ev;
        logic [31:0]     sv;
        bit              typed;
        logic [31:0]     want;
        status_t         want_st;
    } probe_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [MSIZE_W-1:0]   cfg_data = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;

    packed_hessenberg_matrix_store_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    // Shadow copy of the block state
    logic signed [31:0] shadow_q [STORE_DEPTH];
    logic signed [31:0] shadow_b [MAX_N];
    logic signed [31:0] shadow_x [MAX_N];
    logic [MSIZE_W-1:0] shadow_size = MSIZE_RESET;

    row_result_t due_results [$];
    probe_t      directed_q [$];

    int  mismatch_count = 0;
    int  request_count = 0;
    int  result_count = 0;
    int  size_writes = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    bit  quiet_mode = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int eff_size();
        if (shadow_size < 2) return 2;
        if (shadow_size > MAX_N) return MAX_N;
        return int'(shadow_size);
    endfunction

    function automatic int slot_of(input int i, input int j);
        int k;
        k = (i * (i + 3)) / 2 + j;
        return (k < STORE_DEPTH) ? k : 0;
    endfunction

    // Mostly zero, sometimes a few cycles, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_q16();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = Q_MAX;
            1: v = Q_MIN;
            2, 3, 4, 5: v = $urandom;
            default: v = 32'($urandom_range(0, 32'h3FFFF)) - 32'h2_0000;
        endcase
        return v;
    endfunction

    // Expected results of one accepted request; updates the shadow state
    task automatic compute_results(input logic [OP_W-1:0] op, input logic [5:0] r,
                                   input logic [5:0] c, input logic [31:0] ev,
                                   input logic [31:0] sv);
        int          n;
        int          top;
        longint      acc;
        longint      prod;
        row_result_t res;
        n = eff_size();
        res = '{value: '0, index: '0, status: ST_OK, last: 1'b1};
        case (op)
            OP_WRITE: begin
                if (r >= n || c >= n) res.status = ST_RANGE;
                else if (c > r + 1) res.status = ST_ZERO;
                else shadow_q[slot_of(r, c)] = ev;
            end
            OP_READ: begin
                if (r >= n || c >= n) res.status = ST_RANGE;
                else if (c <= r + 1) res.value = shadow_q[slot_of(r, c)];
            end
            OP_IDENT: begin
                for (int i = 0; i < (n * (n + 3)) / 2 && i < STORE_DEPTH; i++)
                    shadow_q[i] = '0;
                for (int i = 0; i < n; i++)
                    shadow_q[slot_of(i, i)] = Q_ONE;
            end
            OP_LOAD: begin
                if (c >= n) begin
                    res.status = ST_RANGE;
                end else begin
                    shadow_b[c] = ev;
                    shadow_x[c] = sv;
                end
            end
            OP_MUL: begin
                for (int i = 0; i < n; i++) begin
                    top = (i + 1 < n) ? i + 1 : n - 1;
                    acc = longint'(shadow_x[i]);
                    for (int j = 0; j <= top; j++) begin
                        prod = longint'(shadow_q[slot_of(i, j)]) * longint'(shadow_b[j]);
                        acc = acc + ((prod + 64'sd32768) >>> 16);
                        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                    end
                    shadow_x[i] = 32'(acc);
                    due_results.push_back('{value: 32'(acc), index: 5'(i), status: ST_OK,
                                            last: (i == n - 1)});
                end
                return;
            end
            default: res.status = ST_RANGE;
        endcase
        due_results.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH result %0d %s: got %0h, want %0h", result_count, what, got, want);
    endtask

    // Result checker
    always @(posedge aclk) begin
        row_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            end else begin
                want = due_results.pop_front();
                if (m_tdata[31:0] !== want.value)
                    report_mismatch("read_value", m_tdata[31:0], want.value);
                if (m_tdata[36:32] !== want.index)
                    report_mismatch("out_index", 32'(m_tdata[36:32]), 32'(want.index));
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (quiet_mode) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 1) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout with %0d results outstanding", due_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [5:0] r,
                                input logic [5:0] c, input logic [31:0] ev,
                                input logic [31:0] sv, input bit typed = 1'b0,
                                input logic [31:0] want = '0,
                                input status_t want_st = ST_OK);
        int gap;
        gap = quiet_mode ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, sv, ev, c, r};
        do @(posedge aclk); while (!s_tready);
        request_count++;
        compute_results(op, r, c, ev, sv);
        if (typed) begin
            void'(due_results.pop_back());
            due_results.push_back('{value: want, index: '0, status: want_st, last: 1'b1});
        end
    endtask

    // Hold the sender until every expected result is out, then let the pipe settle
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_size(input logic [MSIZE_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_size = v;
        size_writes++;
    endtask

    function automatic void probe(input logic [OP_W-1:0] op, input logic [5:0] r,
                                  input logic [5:0] c, input logic [31:0] ev,
                                  input logic [31:0] sv, input bit typed = 1'b0,
                                  input logic [31:0] want = '0,
                                  input status_t st = ST_OK);
        directed_q.push_back('{size_write: 1'b0, op: op, row: r, col: c, ev: ev, sv: sv,
                               typed: typed, want: want, want_st: st});
    endfunction

    function automatic void size_probe(input logic [MSIZE_W-1:0] v);
        directed_q.push_back('{size_write: 1'b1, op: OP_WRITE, row: '0, col: '0,
                               ev: 32'(v), sv: '0, typed: 1'b0, want: '0,
                               want_st: ST_OK});
    endfunction

    task automatic random_request(input int n);
        logic [5:0]  r;
        logic [5:0]  c;
        logic [OP_W-1:0] op;
        int          pick;
        r = 6'($urandom_range(0, 63));
        c = 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 53) begin
            op = (pick < 28) ? OP_WRITE : OP_READ;
            // Mostly inside the band, else anywhere in the field
            if ($urandom_range(0, 99) < 85) begin
                r = 6'($urandom_range(0, n - 1));
                c = 6'($urandom_range(0, (r + 1 < n) ? r + 1 : n - 1));
            end
        end else if (pick < 68) begin
            op = OP_LOAD;
            if ($urandom_range(0, 9) != 0) c = 6'($urandom_range(0, n - 1));
        end else if (pick < 83) begin
            op = OP_MUL;
        end else if (pick < 88) begin
            op = OP_IDENT;
        end else if (pick < 93) begin
            op = OP_W'($urandom_range(OP_UNDEF_A, OP_UNDEF_C));
        end else begin
            op = ($urandom_range(0, 1) == 0) ? OP_WRITE : OP_READ;
            r = 6'($urandom_range(0, n - 1));
        end
        send_request(op, r, c, pick_q16(), pick_q16());
    endtask

    initial begin
        logic [MSIZE_W-1:0] sizes [4];
        int n;
        sizes = '{6'd63, 6'd7, 6'd1, 6'd4};

        // Directed table, run at the reset size first
        probe(OP_WRITE, 0, 0, Q_MAX, 0, 1'b1, '0, ST_OK);
        probe(OP_WRITE, 31, 31, Q_MIN, 0, 1'b1, '0, ST_OK);
        probe(OP_WRITE, 0, 1, 32'h0002_8000, 0, 1'b1, '0, ST_OK);
        probe(OP_WRITE, 0, 2, Q_MAX, 0, 1'b1, '0, ST_ZERO);
        probe(OP_WRITE, 32, 0, Q_MAX, 0, 1'b1, '0, ST_RANGE);
        probe(OP_WRITE, 63, 63, Q_MIN, Q_MAX, 1'b1, '0, ST_RANGE);
        probe(OP_READ, 0, 0, 0, 0, 1'b1, Q_MAX, ST_OK);
        probe(OP_READ, 31, 31, 0, 0, 1'b1, Q_MIN, ST_OK);
        probe(OP_READ, 0, 1, 0, 0);
        probe(OP_READ, 5, 30, 0, 0, 1'b1, '0, ST_OK);
        probe(OP_READ, 0, 32, 0, 0, 1'b1, '0, ST_RANGE);
        probe(OP_LOAD, 0, 32, Q_MAX, Q_MIN, 1'b1, '0, ST_RANGE);
        probe(OP_UNDEF_A, 0, 0, 0, 0, 1'b1, '0, ST_RANGE);
        probe(OP_UNDEF_B, 63, 63, Q_MAX, Q_MAX, 1'b1, '0, ST_RANGE);
        probe(OP_UNDEF_C, 1, 1, Q_MIN, Q_MIN, 1'b1, '0, ST_RANGE);
        size_probe(6'd2);
        probe(OP_IDENT, 0, 0, 0, 0, 1'b1, '0, ST_OK);
        probe(OP_READ, 1, 1, 0, 0, 1'b1, Q_ONE, ST_OK);
        probe(OP_READ, 0, 1, 0, 0, 1'b1, '0, ST_OK);
        probe(OP_READ, 1, 2, 0, 0, 1'b1, '0, ST_RANGE);
        probe(OP_LOAD, 0, 0, Q_ONE, Q_MAX, 1'b1, '0, ST_OK);
        probe(OP_LOAD, 0, 1, Q_MAX, Q_MIN, 1'b1, '0, ST_OK);
        probe(OP_WRITE, 1, 0, Q_MIN, 0, 1'b1, '0, ST_OK);
        probe(OP_MUL, 0, 0, 0, 0);
        probe(OP_MUL, 63, 63, Q_MAX, Q_MAX);
        size_probe(6'd0);
        probe(OP_READ, 1, 0, 0, 0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_q[k]) begin
            if (directed_q[k].size_write) begin
                wait_drain();
                write_size(directed_q[k].ev[MSIZE_W-1:0]);
            end else begin
                send_request(directed_q[k].op, directed_q[k].row, directed_q[k].col,
                             directed_q[k].ev, directed_q[k].sv, directed_q[k].typed,
                             directed_q[k].want, directed_q[k].want_st);
            end
        end

        // Random phases: identity, a full vector load and a multiply, then a random mix
        foreach (sizes[p]) begin
            wait_drain();
            quiet_mode = (p == 2);
            write_size(sizes[p]);
            n = eff_size();
            send_request(OP_IDENT, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                         pick_q16(), pick_q16());
            for (int i = 0; i < n; i++)
                send_request(OP_LOAD, 6'($urandom_range(0, 63)), 6'(i),
                             pick_q16(), pick_q16());
            send_request(OP_MUL, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                         pick_q16(), pick_q16());
            for (int k = 0; k < 5; k++) begin
                if (k == 2) wait_drain();
                random_request(n);
            end
        end

        wait_drain();
        quiet_mode = 1'b0;
        repeat (20) @(posedge aclk);
        $display("Covered %0d requests and %0d results over %0d size settings,",
                 request_count, result_count, size_writes);
        $display("with random stalls on both channels and one stall-free phase.");
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/phms_pkg.sv
hdl/phms_store_mem.sv
hdl/phms_vec_mem.sv
hdl/phms_mac.sv
hdl/phms_ctrl.sv
hdl/packed_hessenberg_matrix_store_unit.sv
sim/tb_packed_hessenberg_matrix_store_unit.sv
